### hdl/eartm_pkg.sv
package eartm_pkg;

  localparam int CordicSteps = 16;
  localparam int OneQ14      = 16384;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [33:0] cq_t;   // CORDIC x/y, Q30 with headroom
  typedef logic signed [31:0] zq_t;   // residual angle, 2^32 = 2*pi

  function automatic zq_t atan_entry(input logic [3:0] idx);
    zq_t r;
    case (idx)
      4'd0:    r = 32'sh20000000;
      4'd1:    r = 32'sh12E4051E;
      4'd2:    r = 32'sh09FB385B;
      4'd3:    r = 32'sh051111D4;
      4'd4:    r = 32'sh028B0D43;
      4'd5:    r = 32'sh0145D7E1;
      4'd6:    r = 32'sh00A2F61E;
      4'd7:    r = 32'sh00517C55;
      4'd8:    r = 32'sh0028BE53;
      4'd9:    r = 32'sh00145F2F;
      4'd10:   r = 32'sh000A2F98;
      4'd11:   r = 32'sh000517CC;
      4'd12:   r = 32'sh00028BE6;
      4'd13:   r = 32'sh000145F3;
      4'd14:   r = 32'sh0000A2FA;
      default: r = 32'sh0000517D;
    endcase
    return r;
  endfunction

  // clamp a wide signed value to +/-1.0 in Q14
  function automatic q14_t clamp_one(input logic signed [47:0] v);
    q14_t r;
    if (v > 48'sd16384)       r = 16'sd16384;
    else if (v < -48'sd16384) r = -16'sd16384;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage

### hdl/euler_angles_to_rotation_matrix_top.sv
// done_o follows an accepted start through the load, CORDIC, fold, product and output registers.
// Throughput: one request per cycle; busy is always low, as the pipeline never stalls.
// The receiver cannot stall: done_o and the r* ports hold for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers are not reset.
// Stages: a load stage, 16 CORDIC steps, a quadrant fold, then two product stages and a round/saturate.
module euler_angles_to_rotation_matrix_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  output logic        done_o,
  output logic signed [15:0] r00_o,
  output logic signed [15:0] r01_o,
  output logic signed [15:0] r02_o,
  output logic signed [15:0] r10_o,
  output logic signed [15:0] r11_o,
  output logic signed [15:0] r12_o,
  output logic signed [15:0] r20_o,
  output logic signed [15:0] r21_o,
  output logic signed [15:0] r22_o
);

  localparam int NS = eartm_pkg::CordicSteps;

  // Never stall: every cycle is an opportunity to accept.
  assign busy = 1'b0;

  // CORDIC pipeline: three lanes (roll, pitch, yaw), one step per stage
  eartm_pkg::cq_t x_q [NS+1][3];
  eartm_pkg::cq_t y_q [NS+1][3];
  eartm_pkg::zq_t z_q [NS+1][3];
  logic [1:0]     quad_q [NS+1][3];
  logic [NS:0]    vld_q;

  logic [15:0] ang [3];
  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  // Load stage: fold the angle to its quadrant and residue
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      x_q[0][l]    <= 34'sh026DD3B6A;
      y_q[0][l]    <= '0;
      z_q[0][l]    <= {2'b00, ang[l][13:0], 16'h0000};
      quad_q[0][l] <= ang[l][15:14];
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        if (!z_q[s][l][31]) begin
          x_q[s+1][l] <= x_q[s][l] - (y_q[s][l] >>> s);
          y_q[s+1][l] <= y_q[s][l] + (x_q[s][l] >>> s);
          z_q[s+1][l] <= z_q[s][l] - eartm_pkg::atan_entry(4'(s));
        end else begin
          x_q[s+1][l] <= x_q[s][l] + (y_q[s][l] >>> s);
          y_q[s+1][l] <= y_q[s][l] - (x_q[s][l] >>> s);
          z_q[s+1][l] <= z_q[s][l] + eartm_pkg::atan_entry(4'(s));
        end
        quad_q[s+1][l] <= quad_q[s][l];
      end
    end
  end

  // Fold stage: round Q30 to Q14, saturate, apply quadrant
  eartm_pkg::q14_t sn_q [3];
  eartm_pkg::q14_t cs_q [3];
  logic            vf_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      automatic logic signed [47:0] ys = 48'(y_q[NS][l] + 34'sd32768) >>> 16;
      automatic logic signed [47:0] xs = 48'(x_q[NS][l] + 34'sd32768) >>> 16;
      automatic eartm_pkg::q14_t s0 = eartm_pkg::clamp_one(ys);
      automatic eartm_pkg::q14_t c0 = eartm_pkg::clamp_one(xs);
      case (quad_q[NS][l])
        2'd0:    begin sn_q[l] <= s0;  cs_q[l] <= c0;  end
        2'd1:    begin sn_q[l] <= c0;  cs_q[l] <= -s0; end
        2'd2:    begin sn_q[l] <= -s0; cs_q[l] <= -c0; end
        default: begin sn_q[l] <= -c0; cs_q[l] <= s0;  end
      endcase
    end
  end

  // Product stage 1: pair products, Q28
  logic signed [31:0] p_cpcy_q, p_cpsy_q, p_cpsr_q, p_crcp_q;
  logic signed [31:0] p_srsp_q, p_crsy_q, p_srsy_q, p_crcy_q, p_crsp_q, p_cysr_q;
  eartm_pkg::q14_t    sp1_q, sy1_q, cy1_q;
  logic               v1_q;

  always_ff @(posedge clk_i) begin
    p_cpcy_q <= cs_q[1] * cs_q[2];
    p_cpsy_q <= cs_q[1] * sn_q[2];
    p_cpsr_q <= cs_q[1] * sn_q[0];
    p_crcp_q <= cs_q[0] * cs_q[1];
    p_srsp_q <= sn_q[0] * sn_q[1];
    p_crsy_q <= cs_q[0] * sn_q[2];
    p_srsy_q <= sn_q[0] * sn_q[2];
    p_crcy_q <= cs_q[0] * cs_q[2];
    p_crsp_q <= cs_q[0] * sn_q[1];
    p_cysr_q <= cs_q[2] * sn_q[0];
    sp1_q    <= sn_q[1];
    sy1_q    <= sn_q[2];
    cy1_q    <= cs_q[2];
  end

  // Product stage 2: triple products and sums, Q42
  logic signed [47:0] e01_q, e02_q, e11_q, e12_q;
  logic signed [31:0] q00_q, q10_q, q21_q, q22_q;
  eartm_pkg::q14_t    sp2_q;
  logic               v2_q;

  always_ff @(posedge clk_i) begin
    e01_q <= 48'(p_srsp_q) * 48'(cy1_q) - (48'(p_crsy_q) <<< 14);
    e02_q <= (48'(p_srsy_q) <<< 14) + 48'(p_crcy_q) * 48'(sp1_q);
    e11_q <= 48'(p_srsp_q) * 48'(sy1_q) + (48'(p_crcy_q) <<< 14);
    e12_q <= 48'(p_crsp_q) * 48'(sy1_q) - (48'(p_cysr_q) <<< 14);
    q00_q <= p_cpcy_q;
    q10_q <= p_cpsy_q;
    q21_q <= p_cpsr_q;
    q22_q <= p_crcp_q;
    sp2_q <= sp1_q;
  end

  // Output stage: round half up, saturate, strobe for one cycle
  function automatic eartm_pkg::q14_t rq28(input logic signed [31:0] v);
    return eartm_pkg::clamp_one(48'(v + 32'sd8192) >>> 14);
  endfunction

  function automatic eartm_pkg::q14_t rq42(input logic signed [47:0] v);
    return eartm_pkg::clamp_one((v + 48'sd134217728) >>> 28);
  endfunction

  always_ff @(posedge clk_i) begin
    r00_o <= rq28(q00_q);
    r01_o <= rq42(e01_q);
    r02_o <= rq42(e02_q);
    r10_o <= rq28(q10_q);
    r11_o <= rq42(e11_q);
    r12_o <= rq42(e12_q);
    r20_o <= eartm_pkg::clamp_one(-48'(sp2_q));
    r21_o <= rq28(q21_q);
    r22_o <= rq28(q22_q);
  end

  // Valid bits travel with the data; reset drops any request in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vf_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NS-1:0], start & ~busy};
      vf_q   <= vld_q[NS];
      v1_q   <= vf_q;
      v2_q   <= v1_q;
      done_o <= v2_q;
    end
  end

endmodule

### hdl/eartm_checker.sv
module eartm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic signed [15:0] r00_o,
  input logic signed [15:0] r20_o,
  input logic signed [15:0] r22_o
);

  // Every done_o pulse must trace back to an accepted request through the valid-bit pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start & ~busy, 21)) else $error("result without request");

  a_outputs_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (r00_o <= 16'sd16384 && r00_o >= -16'sd16384 &&
                r20_o <= 16'sd16384 && r20_o >= -16'sd16384))
    else $error("element beyond one");

  a_diag_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (r22_o <= 16'sd16384 && r22_o >= -16'sd16384))
    else $error("r22 beyond one");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

endmodule

bind euler_angles_to_rotation_matrix_top eartm_checker u_eartm_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .r00_o, .r20_o, .r22_o
);
